@@ hw/rtl/ptcp_pkg.sv @@
// Package for the pulse timing compare planner.
// Holds the status codes, the prescaler table and the long-division step by 250.
// Used by ptcp_div250 and pulse_timing_compare_planner; depends on nothing.
package ptcp_pkg;

	localparam int unsigned PS_WIDTH       = 40;
	localparam int unsigned QUO_WIDTH      = 33;
	localparam int unsigned TICK_WIDTH     = 16;
	localparam int unsigned DIV_STAGES     = 5;
	localparam int unsigned BITS_PER_STAGE = 8;
	localparam int unsigned PRESCALE_COUNT = 6;

	localparam logic [8:0]  TICK_BASE_PS = 9'd250;
	localparam logic [15:0] PER_LIMIT    = 16'hFFDF;

	localparam logic [15:0] MIN_COUNT [PRESCALE_COUNT] = '{
		16'h0060, 16'h0030, 16'h0018, 16'h000C, 16'h0006, 16'h0003
	};

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_READY = 3'd1,
		ST_ZERO      = 3'd2,
		ST_WIDTH     = 3'd3,
		ST_OVERLAP   = 3'd4,
		ST_RANGE     = 3'd5
	} status_t;

	// Remainder and a word that shifts dividend bits out and quotient bits in.
	typedef struct packed {
		logic [7:0]          rem;
		logic [PS_WIDTH-1:0] word;
	} div_state_t;

	// Request control that travels alongside the division.
	typedef struct packed {
		logic [1:0] ch;
		logic       on;
		status_t    status;
	} ctl_t;

	// Eight restoring division steps by 250, one quotient bit each.
	function automatic div_state_t div_step8(div_state_t s);
		div_state_t r;
		logic [8:0] t;
		logic       qbit;
		r = s;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			t = {r.rem, r.word[PS_WIDTH-1]};
			qbit = (t >= TICK_BASE_PS);
			r.rem = qbit ? 8'(t - TICK_BASE_PS) : t[7:0];
			r.word = {r.word[PS_WIDTH-2:0], qbit};
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/pulse_timing_compare_planner.sv @@
// Pulse timing compare planner: checks one channel's timing request and plans
// its prescaler and compare values. Depends on ptcp_pkg and ptcp_div250.
//
// Use: a request (channel, channel_on, pulse_period, width_ps, delay_ps) is taken
// at a clock edge where req_valid is high and req_stall is low. Each request
// gives exactly one result on the result channel, taken where res_valid is high
// and res_stall is low; results leave in request order.
// One request is taken every cycle while req_stall is low; the rate is set
// by the seven-stage pipeline (five stages of division by 250 ps, eight
// quotient bits each, then prescaler choice, then compares).
// When the receiver stalls, the pipeline keeps its items and closes up any
// empty stages; req_stall rises only once the stage ahead of it is full and
// held.
// timer_ready is written through cfg_we and cfg_wdata and clears at reset.
// Reset empties the pipeline at once; no result is shown until a new request.
// A channel at or above CHANNEL_COUNT is treated as switched off.
module pulse_timing_compare_planner
	import ptcp_pkg::*;
#(
	parameter int unsigned CHANNEL_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  channel,
	input  logic        channel_on,
	input  logic [39:0] pulse_period,
	input  logic [39:0] width_ps,
	input  logic [39:0] delay_ps,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  channel_echo,
	output logic [2:0]  status,
	output logic        drive_active,
	output logic [2:0]  prescale,
	output logic [15:0] period_ticks,
	output logic [15:0] rise_ticks,
	output logic [15:0] fall_ticks,
	output logic        rise_at_period
);

	logic                 timer_ready_q;
	logic [7:1]           vld_s;
	logic [7:1]           adv;
	ctl_t                 ctl_in, ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [QUO_WIDTH-1:0] qt, qw, qd;

	// Stage 6 results
	logic [1:0]            ch_s6;
	status_t               status_s6;
	logic                  active_s6;
	logic [2:0]            k_s6;
	logic [TICK_WIDTH-1:0] per_s6, dt_s6, wt_s6;

	// Stage 7 (output register)
	logic [1:0]            ch_s7;
	status_t               status_s7;
	logic                  active_s7;
	logic [2:0]            k_s7;
	logic [TICK_WIDTH-1:0] per_s7, rise_s7, fall_s7;
	logic                  at_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_ready_q <= 1'b0;
		end else if (cfg_we) begin
			timer_ready_q <= cfg_wdata;
		end
	end

	// A stage moves on when it is empty or when the stage after it moves on.
	always_comb begin
		adv[7] = !vld_s[7] || !res_stall;
		for (int i = 6; i >= 1; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign req_stall = !adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[1]) begin
				vld_s[1] <= req_valid;
			end
			for (int i = 2; i <= 7; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// Request checks, in priority order, up to the prescaler range check.
	always_comb begin
		logic [PS_WIDTH:0] dw_sum;
		dw_sum = {1'b0, delay_ps} + {1'b0, width_ps};
		ctl_in.ch = channel;
		ctl_in.on = channel_on && ({1'b0, channel} < 3'(CHANNEL_COUNT));
		if (!ctl_in.on) begin
			ctl_in.status = ST_OK;
		end else if (!timer_ready_q) begin
			ctl_in.status = ST_NOT_READY;
		end else if (pulse_period == '0 || width_ps == '0) begin
			ctl_in.status = ST_ZERO;
		end else if (width_ps >= pulse_period) begin
			ctl_in.status = ST_WIDTH;
		end else if (dw_sum > {1'b0, pulse_period}) begin
			ctl_in.status = ST_OVERLAP;
		end else begin
			ctl_in.status = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ctl_s1 <= ctl_in;
		end
		if (adv[2]) begin
			ctl_s2 <= ctl_s1;
		end
		if (adv[3]) begin
			ctl_s3 <= ctl_s2;
		end
		if (adv[4]) begin
			ctl_s4 <= ctl_s3;
		end
		if (adv[5]) begin
			ctl_s5 <= ctl_s4;
		end
	end

	ptcp_div250 u_div_period (.clk(clk), .adv(adv[5:1]), .din(pulse_period), .quo(qt));
	ptcp_div250 u_div_width  (.clk(clk), .adv(adv[5:1]), .din(width_ps),  .quo(qw));
	ptcp_div250 u_div_delay  (.clk(clk), .adv(adv[5:1]), .din(delay_ps),  .quo(qd));

	// Stage 6: finest prescaler whose period count fits, and the scaled counts.
	always_ff @(posedge clk) begin
		logic [QUO_WIDTH-1:0] cnt;
		logic                 found;
		logic [2:0]           k;
		logic                 ok;
		if (adv[6]) begin
			found = 1'b0;
			k = '0;
			for (int j = PRESCALE_COUNT - 1; j >= 0; j--) begin
				cnt = qt >> j;
				if (cnt <= QUO_WIDTH'(PER_LIMIT) && cnt >= QUO_WIDTH'(MIN_COUNT[j])) begin
					found = 1'b1;
					k = 3'(j);
				end
			end
			ok = ctl_s5.on && (ctl_s5.status == ST_OK) && found;
			ch_s6 <= ctl_s5.ch;
			if (ctl_s5.on && ctl_s5.status == ST_OK && !found) begin
				status_s6 <= ST_RANGE;
			end else begin
				status_s6 <= ctl_s5.status;
			end
			active_s6 <= ok;
			k_s6 <= ok ? k : 3'd0;
			per_s6 <= TICK_WIDTH'(qt >> k);
			dt_s6 <= TICK_WIDTH'(qd >> k);
			wt_s6 <= TICK_WIDTH'(qw >> k);
		end
	end

	// Stage 7: width raised to the minimum, fall clamped below the period.
	always_ff @(posedge clk) begin
		logic [TICK_WIDTH-1:0] mn;
		logic [TICK_WIDTH-1:0] wt;
		logic [TICK_WIDTH:0]   ft;
		logic [TICK_WIDTH-1:0] lim;
		logic                  at;
		if (adv[7]) begin
			mn = MIN_COUNT[k_s6];
			wt = (wt_s6 < mn) ? mn : wt_s6;
			ft = {1'b0, dt_s6} + {1'b0, wt};
			lim = per_s6 - 16'd1;
			at = dt_s6 < mn;
			ch_s7 <= ch_s6;
			status_s7 <= status_s6;
			active_s7 <= active_s6;
			k_s7 <= k_s6;
			if (active_s6) begin
				per_s7 <= per_s6;
				rise_s7 <= at ? '0 : dt_s6;
				fall_s7 <= (ft > {1'b0, lim}) ? lim : ft[TICK_WIDTH-1:0];
				at_s7 <= at;
			end else begin
				per_s7 <= '0;
				rise_s7 <= '0;
				fall_s7 <= '0;
				at_s7 <= 1'b0;
			end
		end
	end

	assign res_valid      = vld_s[7];
	assign channel_echo   = ch_s7;
	assign status         = status_s7;
	assign drive_active   = active_s7;
	assign prescale       = k_s7;
	assign period_ticks   = per_s7;
	assign rise_ticks     = rise_s7;
	assign fall_ticks     = fall_s7;
	assign rise_at_period = at_s7;

	a_active_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && drive_active |-> status_s7 == ST_OK)
		else $error("drive_active set on a request with an error status");

	a_parked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !drive_active |-> period_ticks == '0 && fall_ticks == '0 &&
		prescale == '0 && !rise_at_period)
		else $error("timing fields not zero on a parked result");

	a_fall_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && drive_active |-> fall_ticks < period_ticks && prescale <= 3'd5)
		else $error("fall compare not below the period count");

	a_held_stage: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[6] && !adv[6] |=> vld_s[6] && $stable(per_s6) && $stable(status_s6))
		else $error("stalled stage 6 item changed or was lost");

	a_no_req_stall_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[1] |-> !req_stall)
		else $error("request stalled while the first stage is empty");

endmodule

@@ hw/rtl/ptcp_div250.sv @@
// Pipelined divider of a 40-bit picosecond value by the 250 ps base tick.
// Five register stages of eight quotient bits each; depends on ptcp_pkg.
module ptcp_div250
	import ptcp_pkg::*;
(
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] adv,
	input  logic [PS_WIDTH-1:0]   din,
	output logic [QUO_WIDTH-1:0]  quo
);

	div_state_t dv_s1, dv_s2, dv_s3, dv_s4, dv_s5;
	div_state_t start;

	assign start = '{rem: 8'd0, word: din};

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			dv_s1 <= div_step8(start);
		end
		if (adv[1]) begin
			dv_s2 <= div_step8(dv_s1);
		end
		if (adv[2]) begin
			dv_s3 <= div_step8(dv_s2);
		end
		if (adv[3]) begin
			dv_s4 <= div_step8(dv_s3);
		end
		if (adv[4]) begin
			dv_s5 <= div_step8(dv_s4);
		end
	end

	// The quotient never reaches 2^33, so the upper bits of the word are zero.
	assign quo = dv_s5.word[QUO_WIDTH-1:0];

endmodule
